// ===== hw/rtl/mbs_pkg.sv =====
package mbs_pkg;

  localparam int unsigned MAX_LINE = 4096;
  localparam int unsigned MAX_CELL = 8;

  localparam int unsigned POS_W   = $clog2(MAX_LINE);      // raster and cell counters
  localparam int unsigned LEN_W   = POS_W + 1;             // line length, window size
  localparam int unsigned PHASE_W = $clog2(MAX_CELL);      // phase within a cell
  localparam int unsigned CELL_W  = PHASE_W + 1;           // mosaic size register
  localparam int unsigned BAND_W  = 2 * PHASE_W;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = LEN_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0]   FRAME_WIDTH_RST   = LEN_W'(2048);
  localparam logic [PHASE_W-1:0] WINDOW_X_RST      = '0;
  localparam logic [PHASE_W-1:0] WINDOW_Y_RST      = '0;
  localparam logic [LEN_W-1:0]   WINDOW_WIDTH_RST  = LEN_W'(2048);
  localparam logic [LEN_W-1:0]   WINDOW_HEIGHT_RST = LEN_W'(1088);
  localparam logic [CELL_W-1:0]  MOSAIC_SIZE_RST   = CELL_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_WINDOW_X      = 3'd1,
    CFG_WINDOW_Y      = 3'd2,
    CFG_WINDOW_WIDTH  = 3'd3,
    CFG_WINDOW_HEIGHT = 3'd4,
    CFG_MOSAIC_SIZE   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [BAND_W-1:0] band_index;
    logic [POS_W-1:0]  sub_col;
    logic [POS_W-1:0]  sub_row;
    logic [PIX_W-1:0]  pixel_out;
  } out_t;

endpackage

// ===== hw/rtl/mosaic_band_splitter_top.sv =====
// Mosaic band splitter: sorts the raster stream of a snapshot multispectral
// sensor into spectral bands.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one raw pixel per
// transfer in raster order; frame_start marks the first pixel of a frame and
// clears the raster, phase and cell counters before that pixel is handled.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transfer for
// each pixel inside the configured window, carrying its band index, its
// column and row in the band sub-image and the pixel value. Pixels outside
// the window produce nothing.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i; write
// only while the block is idle.
//
// A result is valid in the cycle after its input transfer. Throughput is one
// pixel per cycle: the counter update and band compute sit between the
// counter registers and a single output register, which is refilled in the
// same cycle it is drained. While the receiver stalls with a result pending,
// in_ready_o drops and the result holds. Reset clears all counters, empties
// the output register and loads the configuration defaults.
module mosaic_band_splitter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mbs_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mbs_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [mbs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mbs_pkg::CFG_W-1:0]         cfg_data_i
);
  import mbs_pkg::*;

  // configuration
  logic [LEN_W-1:0]   frame_width_q, window_width_q, window_height_q;
  logic [PHASE_W-1:0] window_x_q, window_y_q;
  logic [CELL_W-1:0]  mosaic_size_q;

  // counters
  logic [POS_W-1:0]   raster_col_q, raster_col_d, raster_row_q, raster_row_d;
  logic [PHASE_W-1:0] phase_col_q, phase_col_d, phase_row_q, phase_row_d;
  logic [POS_W-1:0]   cell_col_q, cell_col_d, cell_row_q, cell_row_d;

  // output register
  logic out_valid_q, out_valid_d;
  out_t out_data_q, out_data_d;

  // counters as seen by the current pixel (cleared on frame start)
  logic [POS_W-1:0]   rc, rr, cc, cr;
  logic [PHASE_W-1:0] pc, pr;
  logic [CELL_W-1:0]  cell_n;
  logic [LEN_W-1:0]   line_len;
  logic [LEN_W:0]     x_end, y_end;
  logic               cin, rin, pc_wrap, pr_wrap, line_end, row_last, in_xfer;
  logic [2*CELL_W-1:0] band_full;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    rc = in_data_i.frame_start ? '0 : raster_col_q;
    rr = in_data_i.frame_start ? '0 : raster_row_q;
    pc = in_data_i.frame_start ? '0 : phase_col_q;
    pr = in_data_i.frame_start ? '0 : phase_row_q;
    cc = in_data_i.frame_start ? '0 : cell_col_q;
    cr = in_data_i.frame_start ? '0 : cell_row_q;

    // clamp mosaic size and line length into their legal ranges
    if (mosaic_size_q == '0) begin
      cell_n = CELL_W'(1);
    end else if (mosaic_size_q > CELL_W'(MAX_CELL)) begin
      cell_n = CELL_W'(MAX_CELL);
    end else begin
      cell_n = mosaic_size_q;
    end
    if (frame_width_q == '0) begin
      line_len = LEN_W'(1);
    end else if (frame_width_q > LEN_W'(MAX_LINE)) begin
      line_len = LEN_W'(MAX_LINE);
    end else begin
      line_len = frame_width_q;
    end

    x_end = (LEN_W+1)'(window_x_q) + (LEN_W+1)'(window_width_q);
    y_end = (LEN_W+1)'(window_y_q) + (LEN_W+1)'(window_height_q);
    cin   = (rc >= POS_W'(window_x_q)) && ((LEN_W+1)'(rc) < x_end);
    rin   = (rr >= POS_W'(window_y_q)) && ((LEN_W+1)'(rr) < y_end);

    pc_wrap  = (CELL_W'(pc) + CELL_W'(1)) >= cell_n;
    pr_wrap  = (CELL_W'(pr) + CELL_W'(1)) >= cell_n;
    line_end = (LEN_W'(rc) + LEN_W'(1)) >= line_len;
    row_last = (rr == POS_W'(MAX_LINE - 1));

    band_full = (2*CELL_W)'(pr) * (2*CELL_W)'(cell_n) + (2*CELL_W)'(pc);

    // column counters
    if (line_end) begin
      raster_col_d = '0;
      phase_col_d  = '0;
      cell_col_d   = '0;
    end else begin
      raster_col_d = rc + POS_W'(1);
      phase_col_d  = pc;
      cell_col_d   = cc;
      if (cin) begin
        phase_col_d = pc_wrap ? '0 : pc + PHASE_W'(1);
        cell_col_d  = pc_wrap ? cc + POS_W'(1) : cc;
      end
    end

    // row counters advance at line end, row phase only inside the window
    raster_row_d = rr;
    phase_row_d  = pr;
    cell_row_d   = cr;
    if (line_end) begin
      if (row_last) begin
        raster_row_d = '0;
        phase_row_d  = '0;
        cell_row_d   = '0;
      end else begin
        raster_row_d = rr + POS_W'(1);
        if (rin) begin
          phase_row_d = pr_wrap ? '0 : pr + PHASE_W'(1);
          cell_row_d  = pr_wrap ? cr + POS_W'(1) : cr;
        end
      end
    end

    out_data_d.band_index = band_full[BAND_W-1:0];
    out_data_d.sub_col    = cc;
    out_data_d.sub_row    = cr;
    out_data_d.pixel_out  = in_data_i.pixel_in;

    if (in_xfer) begin
      out_valid_d = cin && rin;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= FRAME_WIDTH_RST;
      window_x_q      <= WINDOW_X_RST;
      window_y_q      <= WINDOW_Y_RST;
      window_width_q  <= WINDOW_WIDTH_RST;
      window_height_q <= WINDOW_HEIGHT_RST;
      mosaic_size_q   <= MOSAIC_SIZE_RST;
      raster_col_q    <= '0;
      raster_row_q    <= '0;
      phase_col_q     <= '0;
      phase_row_q     <= '0;
      cell_col_q      <= '0;
      cell_row_q      <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[LEN_W-1:0];
          CFG_WINDOW_X:      window_x_q      <= cfg_data_i[PHASE_W-1:0];
          CFG_WINDOW_Y:      window_y_q      <= cfg_data_i[PHASE_W-1:0];
          CFG_WINDOW_WIDTH:  window_width_q  <= cfg_data_i[LEN_W-1:0];
          CFG_WINDOW_HEIGHT: window_height_q <= cfg_data_i[LEN_W-1:0];
          CFG_MOSAIC_SIZE:   mosaic_size_q   <= cfg_data_i[CELL_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        raster_col_q <= raster_col_d;
        raster_row_q <= raster_row_d;
        phase_col_q  <= phase_col_d;
        phase_row_q  <= phase_row_d;
        cell_col_q   <= cell_col_d;
        cell_row_q   <= cell_row_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/mbs_checker.sv =====
module mbs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mbs_pkg::out_t out_data_o
);
  import mbs_pkg::*;

  // a result only appears after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without input transfer");

  // a stalled result blocks new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result stalled");

  // a drained result with no new input leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !(in_valid_i && in_ready_o)) |=> !out_valid_o)
    else $error("result repeated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output valid dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("stalled output changed");

endmodule

bind mosaic_band_splitter_top mbs_checker u_mbs_checker (.*);

// ===== tb/mbs_checker.sv =====
module mbs_scoreboard
  import mbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LEN_W-1:0]   frame_width;
  logic [PHASE_W-1:0] window_x;
  logic [PHASE_W-1:0] window_y;
  logic [LEN_W-1:0]   window_width;
  logic [LEN_W-1:0]   window_height;
  logic [CELL_W-1:0]  mosaic_size;

  int unsigned raster_col, raster_row;
  int unsigned phase_col, phase_row;
  int unsigned cell_col, cell_row;

  out_t band_q[$];
  out_t want;
  int   mismatches;

  task automatic split_pixel(input in_t px);
    int unsigned n;
    int unsigned len;
    bit          col_in;
    bit          row_in;
    out_t        res;
    n   = (mosaic_size == 0) ? 1 : (mosaic_size > MAX_CELL) ? MAX_CELL : mosaic_size;
    len = (frame_width == 0) ? 1 : (frame_width > MAX_LINE) ? MAX_LINE : frame_width;
    if (px.frame_start) begin
      raster_col = 0;
      raster_row = 0;
      phase_col  = 0;
      phase_row  = 0;
      cell_col   = 0;
      cell_row   = 0;
    end
    col_in = (raster_col >= int'(window_x)) &&
             (raster_col < int'(window_x) + int'(window_width));
    row_in = (raster_row >= int'(window_y)) &&
             (raster_row < int'(window_y) + int'(window_height));
    if (col_in && row_in) begin
      res.band_index = BAND_W'(phase_row * n + phase_col);
      res.sub_col    = POS_W'(cell_col);
      res.sub_row    = POS_W'(cell_row);
      res.pixel_out  = px.pixel_in;
      band_q.push_back(res);
    end
    if (col_in) begin
      if (phase_col + 1 >= n) begin
        phase_col = 0;
        cell_col  = (cell_col + 1) & 12'hFFF;
      end else begin
        phase_col++;
      end
    end
    if (raster_col + 1 >= len) begin
      raster_col = 0;
      phase_col  = 0;
      cell_col   = 0;
      if (row_in) begin
        if (phase_row + 1 >= n) begin
          phase_row = 0;
          cell_row  = (cell_row + 1) & 12'hFFF;
        end else begin
          phase_row++;
        end
      end
      // wrap after the last raster row
      if (raster_row + 1 >= MAX_LINE) begin
        raster_row = 0;
        phase_row  = 0;
        cell_row   = 0;
      end else begin
        raster_row++;
      end
    end else begin
      raster_col++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width   = FRAME_WIDTH_RST;
      window_x      = WINDOW_X_RST;
      window_y      = WINDOW_Y_RST;
      window_width  = WINDOW_WIDTH_RST;
      window_height = WINDOW_HEIGHT_RST;
      mosaic_size   = MOSAIC_SIZE_RST;
      raster_col    = 0;
      raster_row    = 0;
      phase_col     = 0;
      phase_row     = 0;
      cell_col      = 0;
      cell_row      = 0;
      mismatches    = 0;
      band_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_WIDTH:   frame_width   = cfg_data_i;
          CFG_WINDOW_X:      window_x      = cfg_data_i[PHASE_W-1:0];
          CFG_WINDOW_Y:      window_y      = cfg_data_i[PHASE_W-1:0];
          CFG_WINDOW_WIDTH:  window_width  = cfg_data_i;
          CFG_WINDOW_HEIGHT: window_height = cfg_data_i;
          CFG_MOSAIC_SIZE:   mosaic_size   = cfg_data_i[CELL_W-1:0];
          default: ;
        endcase
      end
      // drain before predicting: a result out now belongs to an earlier pixel
      if (out_valid_i && out_ready_i) begin
        if (band_q.size() == 0) begin
          $error("unexpected transfer: band_index %0d sub_col %0d sub_row %0d pixel %0d",
                 out_data_i.band_index, out_data_i.sub_col, out_data_i.sub_row,
                 out_data_i.pixel_out);
          mismatches++;
        end else begin
          want = band_q.pop_front();
          if (out_data_i.band_index !== want.band_index) begin
            $error("band_index: expected %0d, got %0d", want.band_index,
                   out_data_i.band_index);
            mismatches++;
          end
          if (out_data_i.sub_col !== want.sub_col) begin
            $error("sub_col: expected %0d, got %0d", want.sub_col, out_data_i.sub_col);
            mismatches++;
          end
          if (out_data_i.sub_row !== want.sub_row) begin
            $error("sub_row: expected %0d, got %0d", want.sub_row, out_data_i.sub_row);
            mismatches++;
          end
          if (out_data_i.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel_out,
                   out_data_i.pixel_out);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        split_pixel(in_data_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= band_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 260;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int fail_count;
  int bands_pending;

  int   hold_token = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;
  logic rx_quiet   = 1'b0;
  bit   tx_quiet   = 1'b0;
  int   idle_cycles = 0;
  int   random_sent = 0;

  mosaic_band_splitter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mbs_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (bands_pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random backpressure, one long hold-off per token bump
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = 0;
    if (!tx_quiet) begin
      while (($urandom_range(0, 99) < 38) && (gap < 12)) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel_in: pix, frame_start: fs};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // hold off input until every band result is out, then let the pipe settle
  task automatic drain_bands();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (bands_pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] fw, input logic [CFG_W-1:0] wx,
                               input logic [CFG_W-1:0] wy, input logic [CFG_W-1:0] ww,
                               input logic [CFG_W-1:0] wh, input logic [CFG_W-1:0] ms);
    drain_bands();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= fw;
    @(posedge clk_i);
    cfg_index <= CFG_WINDOW_X;
    cfg_data  <= wx;
    @(posedge clk_i);
    cfg_index <= CFG_WINDOW_Y;
    cfg_data  <= wy;
    @(posedge clk_i);
    cfg_index <= CFG_WINDOW_WIDTH;
    cfg_data  <= ww;
    @(posedge clk_i);
    cfg_index <= CFG_WINDOW_HEIGHT;
    cfg_data  <= wh;
    @(posedge clk_i);
    cfg_index <= CFG_MOSAIC_SIZE;
    cfg_data  <= ms;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // raster run: frame start every frame_len pixels, first one on restart, noise_pct adds random ones
  task automatic send_run(input int count, input int frame_len, input bit restart,
                          input int noise_pct);
    for (int i = 0; i < count; i++) begin
      logic fs;
      fs = (i == 0) ? restart : ((i % frame_len) == 0);
      if ($urandom_range(0, 99) < noise_pct) fs = 1'b1;
      push_pixel(PIX_W'($urandom), fs);
    end
  endtask

  function automatic int clamp_len(input int v);
    return (v == 0) ? 1 : (v > MAX_LINE) ? MAX_LINE : v;
  endfunction

  function automatic int pick_window(input int edge_n);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(1, 23);
      2:       return $urandom_range(0, 1) ? 4096 : 8191;
      default: return edge_n * $urandom_range(1, 3);
    endcase
  endfunction

  initial begin
    int ms, n_eff, fw, ww, wh, run_len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults from reset
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h5A, 1'b0);

    // 6-wide frame, 4x2 window at (1,1), 2x2 cells
    load_settings(6, 1, 1, 4, 2, 2);
    for (int i = 0; i < 18; i++) push_pixel(PIX_W'(i * 37), (i == 0));
    // restart at a line start
    push_pixel(8'h81, 1'b1);
    push_pixel(8'h7E, 1'b0);

    // shrink the cell mid-frame with the column phase held above the new edge
    load_settings(16, 0, 0, 16, 8, 8);
    send_run(44, 4096, 1'b1, 0);
    load_settings(16, 0, 0, 16, 8, 3);
    send_run(40, 4096, 1'b0, 0);

    // one-pixel lines down the window rows
    load_settings(0, 0, 3, 8, 4096, 8);
    send_run(60, 8192, 1'b1, 0);

    // oversized line length clamps
    load_settings(8191, 0, 0, 4096, 1, 0);
    send_run(60, 8192, 1'b1, 0);

    // long hold-off on the output with a steady sender, then no idling at all
    load_settings(12, 7, 7, 8, 8, 4);
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    hold_token <= hold_token + 1;
    send_run(160, 12 * 16, 1'b1, 0);
    drain_bands();
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       ms = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
        default: ms = $urandom_range(1, 8);
      endcase
      n_eff   = (ms == 0) ? 1 : (ms > MAX_CELL) ? MAX_CELL : ms;
      fw      = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      ww      = pick_window(n_eff);
      wh      = pick_window(n_eff);
      run_len = $urandom_range(20, 60);
      load_settings(CFG_W'(fw), CFG_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 7)),
                    CFG_W'(ww), CFG_W'(wh), CFG_W'(ms));
      send_run(run_len, clamp_len(fw) * $urandom_range(2, 12), 1'($urandom_range(0, 1)), 3);
      random_sent += run_len;
    end

    drain_bands();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && bands_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
